>>> rtl/core/pst_pkg.sv
// Shared types and constants for the port state table with histogram.
// Used by the controller, the datapath and the top level; depends on nothing.
package pst_pkg;

  localparam int unsigned IP_PROTO_SPACE = 256;
  localparam int unsigned COUNT_W        = 18;
  localparam int unsigned STATE_W        = 3;
  localparam int unsigned NUM_BINS       = 6;
  localparam int unsigned S_TDATA_W      = 24;
  localparam int unsigned M_TDATA_W      = 32;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(15);

  localparam logic [3:0] PS_OPEN = 4'd1;
  localparam logic [3:0] PS_LAST = 4'd6;
  localparam int unsigned PS_FIRST_IGNORABLE = 2;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PROTO_TCP     = 2'd0,
    PROTO_UDP     = 2'd1,
    PROTO_IP      = 2'd2,
    PROTO_INVALID = 2'd3
  } proto_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_BAD_STATE = 2'd2,
    STAT_BAD_ADDR  = 2'd3
  } status_e;

  typedef struct packed {
    logic clearing;
    logic take_req;
    logic execute;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
  } dp_status_t;

endpackage

>>> rtl/core/pst_ctrl.sv
// Controller state machine for the port state table.
// Sequences the clearing pass and each request; uses pst_pkg.
module pst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  pst_pkg::dp_status_t status_i,
  output pst_pkg::ctrl_cmd_t  cmd_o
);
  import pst_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_PICK  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   slot_free;
  logic   take;
  logic   load;

  assign slot_free   = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE) || ((state_q == S_PICK) && slot_free);
  assign take        = req_valid_i && req_ready_o;
  assign load        = (state_q == S_PICK) && slot_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (status_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        if (slot_free) begin
          state_d = take ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o    = rsp_valid_q;
  assign cmd_o.clearing = (state_q == S_CLEAR);
  assign cmd_o.take_req = take;
  assign cmd_o.execute  = (state_q == S_EXEC);
  assign cmd_o.load_out = load;

endmodule

>>> rtl/core/pst_dp.sv
// Datapath of the port state table: entry memory, histogram, total and threshold.
// Driven by pst_ctrl commands; uses pst_pkg.
module pst_dp #(
  parameter int unsigned PORT_SPACE = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pst_pkg::ctrl_cmd_t  cmd_i,
  output pst_pkg::dp_status_t status_o,
  input  logic                cfg_we_i,
  input  logic [17:0]         cfg_wdata_i,
  input  logic [1:0]          command_i,
  input  logic [15:0]         port_number_i,
  input  logic [1:0]          protocol_i,
  input  logic [3:0]          new_state_i,
  output logic [1:0]          rsp_status_o,
  output logic                found_o,
  output logic [2:0]          entry_state_o,
  output logic [2:0]          ignored_state_o,
  output logic [17:0]         total_ports_o
);
  import pst_pkg::*;

  localparam int unsigned TableDepth = 2 * PORT_SPACE + IP_PROTO_SPACE;
  localparam int unsigned SlotW      = $clog2(TableDepth);

  logic [3:0]         mem [TableDepth];
  logic [3:0]         rd_q;
  logic               mem_we;
  logic [SlotW-1:0]   mem_wa;
  logic [3:0]         mem_wd;

  logic [SlotW-1:0]   clr_addr_q;
  logic               clr_last;

  logic [SlotW-1:0]   slot_in;
  logic               addr_ok_in;

  cmd_e               cmd_q;
  logic [3:0]         nst_q;
  logic [SlotW-1:0]   slot_q;
  logic               addr_ok_q;

  logic [COUNT_W-1:0] hist_q [NUM_BINS];
  logic [COUNT_W-1:0] hist_d [NUM_BINS];
  logic [COUNT_W-1:0] total_q, total_d;
  logic [COUNT_W-1:0] thr_q;

  logic               found;
  logic [STATE_W-1:0] old_state;
  logic               nst_legal;
  status_e            status_d;
  logic               do_add;
  logic               do_remove;

  status_e            res_status_q;
  logic               res_found_q;
  logic [STATE_W-1:0] res_old_q;

  logic [STATE_W-1:0] best;
  logic [COUNT_W-1:0] best_cnt;
  logic [STATE_W-1:0] ignored;

  logic [1:0]         out_status_q;
  logic               out_found_q;
  logic [2:0]         out_old_q;
  logic [2:0]         out_ign_q;
  logic [17:0]        out_total_q;

  // Address decode of the incoming request.
  always_comb begin
    slot_in    = '0;
    addr_ok_in = 1'b0;
    case (protocol_i)
      PROTO_TCP: begin
        addr_ok_in = {1'b0, port_number_i} < 17'(PORT_SPACE);
        slot_in    = SlotW'(port_number_i);
      end
      PROTO_UDP: begin
        addr_ok_in = {1'b0, port_number_i} < 17'(PORT_SPACE);
        slot_in    = SlotW'(port_number_i) + SlotW'(PORT_SPACE);
      end
      PROTO_IP: begin
        addr_ok_in = (port_number_i[15:8] == 8'd0);
        slot_in    = SlotW'(port_number_i[7:0]) + SlotW'(2 * PORT_SPACE);
      end
      default: begin
        addr_ok_in = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) begin
      cmd_q     <= cmd_e'(command_i);
      nst_q     <= new_state_i;
      slot_q    <= slot_in;
      addr_ok_q <= addr_ok_in && (cmd_e'(command_i) != CMD_QUERY);
    end
  end

  // Clearing pass over the whole entry memory after reset.
  assign clr_last            = (clr_addr_q == SlotW'(TableDepth - 1));
  assign status_o.clear_done = clr_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clearing && !clr_last) begin
      clr_addr_q <= clr_addr_q + SlotW'(1);
    end
  end

  // Request evaluation.
  assign found     = addr_ok_q && rd_q[3];
  assign old_state = found ? rd_q[2:0] : '0;
  assign nst_legal = (nst_q >= PS_OPEN) && (nst_q <= PS_LAST);

  always_comb begin
    status_d  = STAT_OK;
    do_add    = 1'b0;
    do_remove = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        if (!nst_legal) begin
          status_d = STAT_BAD_STATE;
        end else if (!addr_ok_q) begin
          status_d = STAT_BAD_ADDR;
        end else begin
          do_add = 1'b1;
        end
      end
      CMD_REMOVE, CMD_LOOKUP: begin
        if (!addr_ok_q) begin
          status_d = STAT_BAD_ADDR;
        end else if (!found) begin
          status_d = STAT_NOT_FOUND;
        end else begin
          do_remove = (cmd_q == CMD_REMOVE);
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
  end

  always_comb begin
    for (int b = 0; b < NUM_BINS; b++) begin
      hist_d[b] = hist_q[b];
      if ((do_remove || (do_add && found)) && (old_state == STATE_W'(b + 1)) &&
          (hist_d[b] != '0)) begin
        hist_d[b] = hist_d[b] - COUNT_W'(1);
      end
      if (do_add && (nst_q[2:0] == STATE_W'(b + 1))) begin
        hist_d[b] = hist_d[b] + COUNT_W'(1);
      end
    end
  end

  always_comb begin
    total_d = total_q;
    if (do_add && !found) begin
      total_d = total_q + COUNT_W'(1);
    end else if (do_remove && (total_q != '0)) begin
      total_d = total_q - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        hist_q[b] <= '0;
      end
      total_q <= '0;
      thr_q   <= THRESHOLD_RESET;
    end else begin
      if (cmd_i.execute) begin
        for (int b = 0; b < NUM_BINS; b++) begin
          hist_q[b] <= hist_d[b];
        end
        total_q <= total_d;
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_status_q <= status_d;
      res_found_q  <= found;
      res_old_q    <= old_state;
    end
  end

  // Entry memory: one write and one registered read per cycle.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot_q;
    mem_wd = '0;
    if (cmd_i.clearing) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
    end else if (cmd_i.execute && do_add) begin
      mem_we = 1'b1;
      mem_wd = {1'b1, nst_q[2:0]};
    end else if (cmd_i.execute && do_remove) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.take_req) begin
      rd_q <= mem[slot_in];
    end
  end

  // Most common state other than open, lowest code on a tie; zero if its count is below the threshold.
  always_comb begin
    best     = '0;
    best_cnt = '0;
    for (int b = PS_FIRST_IGNORABLE - 1; b < NUM_BINS; b++) begin
      if (hist_q[b] > best_cnt) begin
        best     = STATE_W'(b + 1);
        best_cnt = hist_q[b];
      end
    end
    ignored = ((best == '0) || (best_cnt < thr_q)) ? '0 : best;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_old_q    <= res_old_q;
      out_ign_q    <= ignored;
      out_total_q  <= total_q;
    end
  end

  assign rsp_status_o    = out_status_q;
  assign found_o         = out_found_q;
  assign entry_state_o   = out_old_q;
  assign ignored_state_o = out_ign_q;
  assign total_ports_o   = out_total_q;

endmodule

>>> rtl/core/port_state_table_with_histogram.sv
// Port state table with state histogram: add, remove, lookup and ignored-state query.
// A request reads the entry memory when accepted, writes it and the histogram in EXEC,
// and loads the output in PICK, where the next request is taken if the output is free.
// After reset a clearing pass writes every one of the 2*PORT_SPACE+256 entries
// (131328 at the default), while no request is taken; configuration is open.
// Reset is asynchronous and active low; it restores the threshold to 15.
module port_state_table_with_histogram #(
  parameter int unsigned PORT_SPACE = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [17:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0], port_number[17:2], protocol[19:18], new_state[23:20]
  input  logic [pst_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], found[2], entry_state[5:3], ignored_state[8:6], total_ports[26:9]
  output logic [pst_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import pst_pkg::*;

  ctrl_cmd_t   cmd;
  dp_status_t  dp_status;
  logic [1:0]  status_field;
  logic        found;
  logic [2:0]  entry_state;
  logic [2:0]  ignored_state;
  logic [17:0] total_ports;

  pst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  pst_dp #(
    .PORT_SPACE (PORT_SPACE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (s_axis_tdata[1:0]),
    .port_number_i   (s_axis_tdata[17:2]),
    .protocol_i      (s_axis_tdata[19:18]),
    .new_state_i     (s_axis_tdata[23:20]),
    .rsp_status_o    (status_field),
    .found_o         (found),
    .entry_state_o   (entry_state),
    .ignored_state_o (ignored_state),
    .total_ports_o   (total_ports)
  );

  assign m_axis_tdata = {5'd0, total_ports, ignored_state, entry_state, found, status_field};

endmodule
